// ===== hw/rtl/hrhp_pkg.sv =====
// Shared types, character codes and match tables for the HTTP request head parser.
// No dependencies; every other file of the parser imports this package.
package hrhp_pkg;

    typedef enum logic [3:0] {
        PH_START,
        PH_METHOD,
        PH_URI,
        PH_VER,
        PH_LINE,
        PH_KEY,
        PH_VAL1,
        PH_VAL2,
        PH_DONE,
        PH_ERR
    } phase_t;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;

    localparam logic [2:0] ROLE_SKIP   = 3'd0;
    localparam logic [2:0] ROLE_METHOD = 3'd1;
    localparam logic [2:0] ROLE_URI    = 3'd2;
    localparam logic [2:0] ROLE_VER    = 3'd3;
    localparam logic [2:0] ROLE_KEY    = 3'd4;
    localparam logic [2:0] ROLE_VALUE  = 3'd5;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_METHOD_BAD  = 2'd1;
    localparam logic [1:0] ST_BAD_REQUEST = 2'd2;
    localparam logic [1:0] ST_VERSION_BAD = 2'd3;

    localparam int NUM_METHODS = 5;
    localparam logic [3:0] POS_MAX     = 4'd15;
    localparam logic [3:0] VER_END_POS = 4'd8;
    localparam logic [3:0] VER_DONE    = 4'd9;

    localparam logic [7:0] METH_TEXT [0:NUM_METHODS-1][0:7] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] METH_LEN [0:NUM_METHODS-1] = '{4'd3, 4'd4, 4'd6, 4'd4, 4'd3};
    localparam logic [7:0] VER_TEXT [0:7] = '{"H", "T", "T", "P", "/", "1", ".", "1"};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_word_t;

    typedef struct packed {
        logic [2:0] byte_role;
        logic       field_end;
        logic [2:0] method_code;
        logic       method_known;
        logic       headers_done;
        logic [1:0] status;
    } result_t;

    function automatic logic [NUM_METHODS-1:0] method_hits(input logic [3:0] pos,
                                                          input logic [7:0] b);
        logic [NUM_METHODS-1:0] hits;
        for (int i = 0; i < NUM_METHODS; i++) begin
            hits[i] = (pos < METH_LEN[i]) && (METH_TEXT[i][pos[2:0]] == b);
        end
        return hits;
    endfunction

    function automatic logic version_byte_ok(input logic [3:0] pos, input logic [7:0] b);
        logic ok;
        if (pos < VER_END_POS) begin
            ok = (VER_TEXT[pos[2:0]] == b);
        end
        else if (pos == VER_END_POS) begin
            ok = (b == CH_CR);
        end
        else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [3:0] sat_inc(input logic [3:0] pos);
        return (pos == POS_MAX) ? pos : pos + 4'd1;
    endfunction

endpackage

// ===== hw/rtl/hrhp_in_stage.sv =====
// Input register of the HTTP request head parser: holds one accepted word.
// Depends on hrhp_pkg for the word type.
module hrhp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              restart,
    input  logic              take,
    output logic              word_valid,
    output hrhp_pkg::in_word_t word
);
    import hrhp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end
        else if (take) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            word_reg <= '{data_byte: data_byte, restart: restart};
        end
    end

endmodule

// ===== hw/rtl/hrhp_core.sv =====
// Parser state machine: classifies one byte per step and updates the parse state.
// Depends on hrhp_pkg for the phase type, character codes and match tables.
module hrhp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  hrhp_pkg::in_word_t word,
    output hrhp_pkg::result_t  res
);
    import hrhp_pkg::*;

    phase_t                 phase_reg, phase_next, ph_cur;
    logic [7:0]             last_byte_reg, last_byte_next, lb_cur;
    logic [NUM_METHODS-1:0] cand_reg, cand_next, cand_cur;
    logic [3:0]             pos_reg, pos_next, pos_cur;
    logic                   vok_reg, vok_next, vok_cur;
    logic [2:0]             method_reg, method_next, method_cur;
    logic [1:0]             err_reg, err_next, err_cur;

    logic [7:0] b;
    logic       found;
    logic [2:0] found_idx;
    logic       known;
    logic       lf_ok;

    assign b = word.data_byte;

    // A restart word is parsed as if the state had just been reset.
    always_comb
    begin
        if (word.restart) begin
            ph_cur     = PH_START;
            lb_cur     = 8'd0;
            cand_cur   = '1;
            pos_cur    = 4'd0;
            vok_cur    = 1'b1;
            method_cur = 3'd0;
            err_cur    = ST_OK;
        end
        else begin
            ph_cur     = phase_reg;
            lb_cur     = last_byte_reg;
            cand_cur   = cand_reg;
            pos_cur    = pos_reg;
            vok_cur    = vok_reg;
            method_cur = method_reg;
            err_cur    = err_reg;
        end
    end

    always_comb
    begin
        found     = 1'b0;
        found_idx = 3'd0;
        for (int i = 0; i < NUM_METHODS; i++) begin
            if (cand_cur[i] && (METH_LEN[i] == pos_cur)) begin
                found     = 1'b1;
                found_idx = 3'(i);
            end
        end
    end

    assign lf_ok = (lb_cur == CH_CR);

    always_comb
    begin
        phase_next     = ph_cur;
        last_byte_next = b;
        cand_next      = cand_cur;
        pos_next       = pos_cur;
        vok_next       = vok_cur;
        method_next    = method_cur;
        err_next       = err_cur;
        unique case (ph_cur)
            PH_START: begin
                if (b != CH_SP && b != CH_TAB && b != CH_CR && b != CH_LF) begin
                    cand_next  = method_hits(4'd0, b);
                    pos_next   = 4'd1;
                    phase_next = PH_METHOD;
                end
            end
            PH_METHOD: begin
                if (b != CH_SP) begin
                    cand_next = cand_cur & method_hits(pos_cur, b);
                    pos_next  = sat_inc(pos_cur);
                end
                else if (found) begin
                    method_next = found_idx;
                    phase_next  = PH_URI;
                end
                else begin
                    err_next   = ST_METHOD_BAD;
                    phase_next = PH_ERR;
                end
            end
            PH_URI: begin
                if (b == CH_SP) begin
                    pos_next   = 4'd0;
                    vok_next   = 1'b1;
                    phase_next = PH_VER;
                end
            end
            PH_VER: begin
                if (b != CH_LF) begin
                    vok_next = vok_cur && version_byte_ok(pos_cur, b);
                    pos_next = sat_inc(pos_cur);
                end
                else if (!lf_ok) begin
                    err_next   = ST_BAD_REQUEST;
                    phase_next = PH_ERR;
                end
                else if (vok_cur && pos_cur == VER_DONE) begin
                    phase_next = PH_LINE;
                end
                else begin
                    err_next   = ST_VERSION_BAD;
                    phase_next = PH_ERR;
                end
            end
            PH_LINE: begin
                if (b == CH_LF) begin
                    if (!lf_ok) begin
                        err_next   = ST_BAD_REQUEST;
                        phase_next = PH_ERR;
                    end
                    else begin
                        phase_next = PH_DONE;
                    end
                end
                else if (b == CH_COLON) begin
                    phase_next = PH_VAL1;
                end
                else if (b != CH_CR) begin
                    phase_next = PH_KEY;
                end
            end
            PH_KEY: begin
                if (b == CH_COLON) begin
                    phase_next = PH_VAL1;
                end
            end
            PH_VAL1, PH_VAL2: begin
                if (b == CH_LF) begin
                    if (!lf_ok) begin
                        err_next   = ST_BAD_REQUEST;
                        phase_next = PH_ERR;
                    end
                    else begin
                        phase_next = PH_LINE;
                    end
                end
                else if (ph_cur == PH_VAL1 && b != CH_SP && b != CH_TAB && b != CH_CR) begin
                    phase_next = PH_VAL2;
                end
            end
            PH_DONE, PH_ERR: begin
            end
            default: begin
                phase_next = PH_ERR;
            end
        endcase
    end

    assign known = ((phase_next >= PH_URI) && (phase_next <= PH_DONE)) ||
                   ((phase_next == PH_ERR) && (err_next != ST_OK) && (err_next != ST_METHOD_BAD));

    always_comb
    begin
        res.byte_role    = ROLE_SKIP;
        res.field_end    = 1'b0;
        res.headers_done = 1'b0;
        res.method_known = known;
        res.method_code  = known ? method_next : 3'd0;
        res.status       = err_next;
        unique case (ph_cur)
            PH_START: begin
                if (b != CH_SP && b != CH_TAB && b != CH_CR && b != CH_LF) begin
                    res.byte_role = ROLE_METHOD;
                end
            end
            PH_METHOD: begin
                if (b != CH_SP) begin
                    res.byte_role = ROLE_METHOD;
                end
                else begin
                    res.field_end = found;
                end
            end
            PH_URI: begin
                if (b != CH_SP) begin
                    res.byte_role = ROLE_URI;
                end
                else begin
                    res.field_end = 1'b1;
                end
            end
            PH_VER: begin
                if (b != CH_LF) begin
                    res.byte_role = (b == CH_CR) ? ROLE_SKIP : ROLE_VER;
                end
                else begin
                    res.field_end = lf_ok && vok_cur && (pos_cur == VER_DONE);
                end
            end
            PH_LINE: begin
                if (b == CH_LF) begin
                    res.headers_done = lf_ok;
                end
                else if (b == CH_COLON) begin
                    res.field_end = 1'b1;
                end
                else if (b != CH_CR) begin
                    res.byte_role = ROLE_KEY;
                end
            end
            PH_KEY: begin
                if (b == CH_COLON) begin
                    res.field_end = 1'b1;
                end
                else begin
                    res.byte_role = ROLE_KEY;
                end
            end
            PH_VAL1, PH_VAL2: begin
                if (b == CH_LF) begin
                    res.field_end = lf_ok;
                end
                else if (b != CH_CR && (ph_cur == PH_VAL2 || (b != CH_SP && b != CH_TAB))) begin
                    res.byte_role = ROLE_VALUE;
                end
            end
            PH_DONE, PH_ERR: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_START;
            last_byte_reg <= 8'd0;
            cand_reg      <= '1;
            pos_reg       <= 4'd0;
            vok_reg       <= 1'b1;
            method_reg    <= 3'd0;
            err_reg       <= ST_OK;
        end
        else if (step) begin
            phase_reg     <= phase_next;
            last_byte_reg <= last_byte_next;
            cand_reg      <= cand_next;
            pos_reg       <= pos_next;
            vok_reg       <= vok_next;
            method_reg    <= method_next;
            err_reg       <= err_next;
        end
    end

endmodule

// ===== hw/rtl/hrhp_out_stage.sv =====
// Result register of the HTTP request head parser, decoupling it from the consumer.
// Depends on hrhp_pkg for the result type.
module hrhp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hrhp_pkg::result_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        byte_role,
    output logic              field_end,
    output logic [2:0]        method_code,
    output logic              method_known,
    output logic              headers_done,
    output logic [1:0]        status
);
    import hrhp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free         = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign byte_role    = res_reg.byte_role;
    assign field_end    = res_reg.field_end;
    assign method_code  = res_reg.method_code;
    assign method_known = res_reg.method_known;
    assign headers_done = res_reg.headers_done;
    assign status       = res_reg.status;

    always_comb
    begin
        if (load) begin
            valid_next = 1'b1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ===== hw/rtl/http_request_head_parser_top.sv =====
// HTTP request head parser, top level: input register, parser core, result register.
// Depends on hrhp_pkg, hrhp_in_stage, hrhp_core and hrhp_out_stage.
//
// The parser takes one request byte per word and returns one classification word
// per byte, at a sustained rate of one word per clock cycle while out_ready stays
// high. Each byte is held in the input register, parsed by the core and its result
// captured in the result register; the state update of the parser core is what
// sets the rate. Setting restart on a word starts a new request with that byte.
// Errors stay in status until the next restart, and all bytes after the end of
// the headers are reported as skipped.
module http_request_head_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] byte_role,
    output logic       field_end,
    output logic [2:0] method_code,
    output logic       method_known,
    output logic       headers_done,
    output logic [1:0] status
);
    import hrhp_pkg::*;

    logic     word_valid;
    in_word_t word;
    result_t  res;
    logic     free;
    logic     step;

    assign step = word_valid && free;

    hrhp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .restart    (restart),
        .take       (step),
        .word_valid (word_valid),
        .word       (word)
    );

    hrhp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .word  (word),
        .res   (res)
    );

    hrhp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step),
        .res          (res),
        .free         (free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_role    (byte_role),
        .field_end    (field_end),
        .method_code  (method_code),
        .method_known (method_known),
        .headers_done (headers_done),
        .status       (status)
    );

    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("parsed word did not reach the result register");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && headers_done |-> method_known && status == ST_OK && byte_role == ROLE_SKIP)
        else $error("end of headers reported without a known method or with an error");

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> byte_role == ROLE_SKIP && !field_end && !headers_done)
        else $error("byte classified while an error is latched");

    a_code_needs_method: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !method_known |-> method_code == 3'd0)
        else $error("method code given before a method is known");

endmodule
